### design/binary_to_decimal_digits_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal digits block
// Concurrent checks that drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_DIGITS_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define B2D_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("b2d check failed");

// Next-cycle implication
`define B2D_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("b2d check failed");

`else

`define B2D_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define B2D_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### design/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg
// Widths, constants, pipeline word type and the shift-add-3 step.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGIT_COUNT     = 10;
    localparam int NIBBLE_W        = 4;
    localparam int BCD_W           = DIGIT_COUNT * NIBBLE_W;
    localparam int STAGE_COUNT     = 8;
    localparam int STEPS_PER_STAGE = VALUE_W / STAGE_COUNT;
    localparam int CHAR_W          = 6;
    localparam int POS_W           = 4;
    localparam int TDATA_IN_W      = 32;
    localparam int TDATA_OUT_W     = 8;

    localparam logic [CHAR_W-1:0]   ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0]   ASCII_NINE = 6'd57;
    localparam logic [NIBBLE_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [NIBBLE_W-1:0] DABBLE_ADD = 4'd3;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } b2d_word_t;

    // one double-dabble step: add 3 to every digit >= 5, then shift left by one
    function automatic b2d_word_t dabble_step(input b2d_word_t w);
        b2d_word_t        r;
        logic [BCD_W-1:0] adj;
        adj = w.bcd;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (adj[i*NIBBLE_W +: NIBBLE_W] >= DABBLE_MIN)
            begin
                adj[i*NIBBLE_W +: NIBBLE_W] = adj[i*NIBBLE_W +: NIBBLE_W] + DABBLE_ADD;
            end
        end
        r.bcd = {adj[BCD_W-2:0], w.bin[VALUE_W-1]};
        r.bin = {w.bin[VALUE_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

### design/b2d_dabble_stage.sv
// ----------------------------------------------------------------------------
// b2d_dabble_stage
// One elastic pipeline stage doing a fixed group of shift-add-3 steps.
// ----------------------------------------------------------------------------
module b2d_dabble_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  b2d_pkg::b2d_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output b2d_pkg::b2d_word_t out_word
);
    import b2d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    b2d_word_t word_reg;
    b2d_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next = in_word;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            word_next = dabble_step(word_next);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### design/b2d_digit_emit.sv
// ----------------------------------------------------------------------------
// b2d_digit_emit
// Holds one BCD number and sends its significant digits out as ASCII.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_digits_top_macros.svh"

module b2d_digit_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [b2d_pkg::BCD_W-1:0]        in_bcd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [b2d_pkg::CHAR_W-1:0]       out_char,
    output logic                             out_last
);
    import b2d_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [BCD_W-1:0]    bcd_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [CHAR_W-1:0]   char_next;
    logic                last_reg;
    logic                last_next;
    logic [POS_W-1:0]    top_pos;
    logic [NIBBLE_W-1:0] cur_digit;
    logic                accept;
    logic                load;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign load     = busy_reg && (!out_valid_reg || out_ready);

    // highest nonzero digit; zero input gives position 0 -> single '0'
    always_comb
    begin
        top_pos = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (in_bcd[i*NIBBLE_W +: NIBBLE_W] != '0)
            begin
                top_pos = POS_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[pos_reg*NIBBLE_W +: NIBBLE_W];

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        char_next      = ASCII_ZERO + {{(CHAR_W-NIBBLE_W){1'b0}}, cur_digit};
        last_next      = (pos_reg == '0);
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            pos_next  = top_pos;
        end
        else if (load)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg - 1'b1;
            if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bcd_reg <= in_bcd;
        end
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    `B2D_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `B2D_ASSERT_NXT(a_last_frees, clk, rst_n, load && (pos_reg == '0), !busy_reg && out_valid_reg && last_reg)
    `B2D_ASSERT_IMP(a_pos_range, clk, rst_n, busy_reg, pos_reg < POS_W'(DIGIT_COUNT))
    `B2D_ASSERT_IMP(a_char_range, clk, rst_n, out_valid_reg, (char_reg >= ASCII_ZERO) && (char_reg <= ASCII_NINE))

endmodule

### design/binary_to_decimal_digits_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_top
// Path: an accepted word passes the 8 dabble stage registers, then the
//   emitter's number register and then its output register, which presents
//   the first digit.
// Throughput: the emitter takes a number only while idle and takes no new one
//   until its last digit is loaded; the dabble pipeline takes a word every
//   cycle unless stalled and holds up to 8 numbers while the emitter drains.
// Reset: rst_n clears all valid bits and the emitter state asynchronously.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [b2d_pkg::TDATA_IN_W-1:0]    s_tdata,   // [31:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b2d_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                              m_tlast    // last_digit
);
    import b2d_pkg::*;

    // Pipeline links: index 0 is the input port, index STAGE_COUNT feeds the
    // emitter. Each stage runs STEPS_PER_STAGE shift-add-3 steps, so after
    // all stages the binary part is shifted out and bcd holds ten digits.
    logic      link_valid [STAGE_COUNT+1];
    logic      link_ready [STAGE_COUNT+1];
    b2d_word_t link_word  [STAGE_COUNT+1];

    logic [CHAR_W-1:0] emit_char;

    assign link_valid[0]    = s_tvalid;
    assign link_word[0].bcd = '0;
    assign link_word[0].bin = s_tdata[VALUE_W-1:0];
    assign s_tready         = link_ready[0];

    for (genvar g = 0; g < STAGE_COUNT; g++)
    begin : g_stage
        b2d_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_word   (link_word[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_word  (link_word[g+1])
        );
    end

    // Emitter walks down from the top significant digit; it stalls the
    // pipeline while a number is being sent.
    b2d_digit_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[STAGE_COUNT]),
        .in_ready  (link_ready[STAGE_COUNT]),
        .in_bcd    (link_word[STAGE_COUNT].bcd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (emit_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_OUT_W-CHAR_W){1'b0}}, emit_char};

endmodule
